### hw/rtl/vpe_pkg.sv
// Shared types, codes and encoding tables of the varint prefix encoder.
package vpe_pkg;

   localparam int unsigned VPE_QUEUE_DEPTH = 2;

   // Type modes on the request channel.
   localparam logic [2:0] MODE_S16 = 3'd0;
   localparam logic [2:0] MODE_U16 = 3'd1;
   localparam logic [2:0] MODE_S32 = 3'd2;
   localparam logic [2:0] MODE_U32 = 3'd3;
   localparam logic [2:0] MODE_S64 = 3'd4;
   localparam logic [2:0] MODE_U64 = 3'd5;

   // Status codes on the response channel.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_ROOM  = 2'd2;

   // One classified item, as handed from the front end to the back end.
   // The data is left aligned with the prefix already merged into the top byte.
   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  beats;
      logic [3:0]  length;
      logic [1:0]  status;
   } vpe_item_type;

   function automatic logic [63:0] vpe_type_mask(input logic [2:0] mode);
      logic [63:0] mask;
      unique case (mode) inside
         MODE_S16, MODE_U16: mask = 64'h0000_0000_0000_FFFF;
         MODE_S32, MODE_U32: mask = 64'h0000_0000_FFFF_FFFF;
         MODE_S64, MODE_U64: mask = 64'hFFFF_FFFF_FFFF_FFFF;
         default:            mask = 64'h0;
      endcase
      return mask;
   endfunction

   function automatic logic [7:0] vpe_sign_flag(input logic [2:0] mode);
      logic [7:0] flag;
      unique case (mode) inside
         MODE_S16:           flag = 8'h40;
         MODE_S32, MODE_S64: flag = 8'h20;
         default:            flag = 8'h00;
      endcase
      return flag;
   endfunction

   function automatic logic [2:0] vpe_class_count(input logic [2:0] mode);
      logic [2:0] count;
      unique case (mode) inside
         MODE_S16, MODE_U16:                     count = 3'd2;
         MODE_S32, MODE_U32, MODE_S64, MODE_U64: count = 3'd4;
         default:                                count = 3'd0;
      endcase
      return count;
   endfunction

   function automatic logic [63:0] vpe_class_limit(input logic [2:0] mode,
                                                   input logic [1:0] cls);
      logic [63:0] limit;
      limit = 64'h0;
      unique case (mode)
         MODE_S16: begin
            case (cls)
               2'd0:    limit = 64'h3F;
               2'd1:    limit = 64'h3FFF;
               default: limit = 64'h0;
            endcase
         end
         MODE_U16: begin
            case (cls)
               2'd0:    limit = 64'h7F;
               2'd1:    limit = 64'h7FFF;
               default: limit = 64'h0;
            endcase
         end
         MODE_S32: begin
            case (cls)
               2'd0:    limit = 64'h1F;
               2'd1:    limit = 64'h1FFF;
               2'd2:    limit = 64'h1F_FFFF;
               default: limit = 64'h1FFF_FFFF;
            endcase
         end
         MODE_U32: begin
            case (cls)
               2'd0:    limit = 64'h3F;
               2'd1:    limit = 64'h3FFF;
               2'd2:    limit = 64'h3F_FFFF;
               default: limit = 64'h3FFF_FFFF;
            endcase
         end
         MODE_S64: begin
            case (cls)
               2'd0:    limit = 64'h1F;
               2'd1:    limit = 64'h1FFF;
               2'd2:    limit = 64'h1FFF_FFFF;
               default: limit = 64'h1FFF_FFFF_FFFF_FFFF;
            endcase
         end
         MODE_U64: begin
            case (cls)
               2'd0:    limit = 64'h3F;
               2'd1:    limit = 64'h3FFF;
               2'd2:    limit = 64'h3FFF_FFFF;
               default: limit = 64'h3FFF_FFFF_FFFF_FFFF;
            endcase
         end
         default: limit = 64'h0;
      endcase
      return limit;
   endfunction

   function automatic logic [3:0] vpe_class_len(input logic [2:0] mode,
                                               input logic [1:0] cls);
      logic [3:0] len;
      unique case (mode) inside
         MODE_S16, MODE_U16: len = (cls == 2'd0) ? 4'd1 : 4'd2;
         MODE_S32, MODE_U32: len = 4'({2'b00, cls} + 3'd1);
         MODE_S64, MODE_U64: begin
            case (cls)
               2'd0:    len = 4'd1;
               2'd1:    len = 4'd2;
               2'd2:    len = 4'd4;
               default: len = 4'd8;
            endcase
         end
         default: len = 4'd0;
      endcase
      return len;
   endfunction

   function automatic logic [7:0] vpe_class_prefix(input logic [2:0] mode,
                                                  input logic [1:0] cls);
      logic [7:0] prefix;
      unique case (mode) inside
         MODE_S16, MODE_U16: prefix = (cls == 2'd0) ? 8'h00 : 8'h80;
         default:            prefix = {cls, 6'b0};
      endcase
      return prefix;
   endfunction

endpackage

### hw/rtl/vpe_front.sv
// Front end: takes the magnitude, picks the length class and aligns the bytes.
module vpe_front
   import vpe_pkg::*;
(
   input  logic [2:0]   req_mode,
   input  logic [63:0]  req_value,
   input  logic [3:0]   req_room,
   output vpe_item_type item
);

   logic [63:0] mask;
   logic [63:0] raw;
   logic [63:0] mag;
   logic [63:0] aligned;
   logic        neg;
   logic [7:0]  neg_byte;
   logic [2:0]  ncls;
   logic        found;
   logic [1:0]  chosen;
   logic [3:0]  n;

   always_comb begin
      mask = vpe_type_mask(req_mode);
      raw  = req_value & mask;
      // The top bit of the type sits where the mask and the mask shifted down differ.
      neg  = (vpe_sign_flag(req_mode) != 8'h00) && ((raw & (mask ^ (mask >> 1))) != 64'h0);
      mag  = neg ? ((~raw + 64'd1) & mask) : raw;
      neg_byte = neg ? vpe_sign_flag(req_mode) : 8'h00;
      ncls = vpe_class_count(req_mode);

      // Every limit is all ones below some bit, so a fit is a zero test above it.
      found  = 1'b0;
      chosen = 2'd0;
      for (int c = 3; c >= 0; c--) begin
         if ((3'(c) < ncls) && ((mag & ~vpe_class_limit(req_mode, 2'(c))) == 64'h0)) begin
            found  = 1'b1;
            chosen = 2'(c);
         end
      end
      n = vpe_class_len(req_mode, chosen);

      case (n)
         4'd1:    aligned = {mag[7:0],  56'h0};
         4'd2:    aligned = {mag[15:0], 48'h0};
         4'd3:    aligned = {mag[23:0], 40'h0};
         4'd4:    aligned = {mag[31:0], 32'h0};
         default: aligned = mag;
      endcase
      aligned[63:56] = aligned[63:56] | vpe_class_prefix(req_mode, chosen) | neg_byte;

      if (!found) begin
         item.data   = 64'h0;
         item.beats  = 4'd1;
         item.length = 4'd0;
         item.status = ST_RANGE;
      end else if (req_room < n) begin
         item.data   = 64'h0;
         item.beats  = 4'd1;
         item.length = 4'd0;
         item.status = ST_ROOM;
      end else begin
         item.data   = aligned;
         item.beats  = n;
         item.length = n;
         item.status = ST_OK;
      end
   end

endmodule

### hw/rtl/vpe_queue.sv
// Small register queue that decouples the front end from the back end.
module vpe_queue
   import vpe_pkg::*;
#(
   parameter int unsigned DEPTH = VPE_QUEUE_DEPTH
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  vpe_item_type push_item,
   input  logic         pop,
   output vpe_item_type pop_item,
   output logic         full,
   output logic         empty
);

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   vpe_item_type  entries_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CW'(1);
         2'b01:   count_in = count_ff - CW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### hw/rtl/vpe_back.sv
// Back end: shifts out one encoded byte per cycle, most significant first.
module vpe_back
   import vpe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  vpe_item_type item,
   output logic         pop,
   output logic         rsp_strobe,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_last,
   output logic [1:0]   rsp_status,
   output logic [3:0]   rsp_length
);

   logic        active_ff, active_in;
   logic [63:0] data_ff, data_in;
   logic [3:0]  left_ff, left_in;
   logic [3:0]  length_ff, length_in;
   logic [1:0]  status_ff, status_in;
   logic        finishing;

   assign finishing = !active_ff || (left_ff == 4'd1);
   assign pop       = finishing && item_valid;

   always_comb begin
      active_in = active_ff;
      data_in   = data_ff;
      left_in   = left_ff;
      length_in = length_ff;
      status_in = status_ff;
      if (!finishing) begin
         data_in = {data_ff[55:0], 8'h00};
         left_in = left_ff - 4'd1;
      end else begin
         active_in = item_valid;
         if (item_valid) begin
            data_in   = item.data;
            left_in   = item.beats;
            length_in = item.length;
            status_in = item.status;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff   <= data_in;
      left_ff   <= left_in;
      length_ff <= length_in;
      status_ff <= status_in;
   end

   assign rsp_strobe   = active_ff;
   assign rsp_out_byte = data_ff[63:56];
   assign rsp_last     = (left_ff == 4'd1);
   assign rsp_status   = status_ff;
   assign rsp_length   = length_ff;

endmodule

### hw/rtl/varint_prefix_encoder.sv
// Top level of the length-prefixed variable-length integer encoder.
//
// A request beat (req_mode, req_value, req_room) is taken at a rising clock
// edge at which start is high and busy is low. Each request gives one to eight
// response beats on the rsp_ ports, each shown for exactly one cycle with
// rsp_strobe high and rsp_last high on the final beat. A value out of range, or
// too little room, gives a single beat carrying the status and a zero byte.
// The front end classifies a request in the cycle it is taken and writes it
// into a queue of QUEUE_DEPTH entries; busy is high while that queue is full.
// The back end takes one entry at a time and shifts out one byte per cycle, so
// a request that encodes to n bytes gives n beats and an error request one.
// A request is written into a queue entry and then loaded into the back end's
// shift register, from which its first beat is shown; the beats of successive
// requests follow one another with no gap while requests keep arriving.
// Sustained throughput is therefore set by the byte shifter in the back end:
// one byte per cycle, up to eight bytes per request. The receiver cannot
// stall, so nothing on the response side ever waits. A synchronous reset
// empties the queue and drops any beats in flight.
module varint_prefix_encoder
   import vpe_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = VPE_QUEUE_DEPTH
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic [63:0] req_value,
   input  logic [3:0]  req_room,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_length
);

   vpe_item_type front_item;
   vpe_item_type queue_item;
   logic         queue_full;
   logic         queue_empty;
   logic         queue_pop;
   logic         accept;

   // A request is taken whenever the queue has a free entry.
   assign busy   = queue_full;
   assign accept = start && !queue_full;

   vpe_front u_front (
      .req_mode  (req_mode),
      .req_value (req_value),
      .req_room  (req_room),
      .item      (front_item)
   );

   vpe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_item (front_item),
      .pop       (queue_pop),
      .pop_item  (queue_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   // The back end loads the next entry in the same cycle as it shows the last
   // beat of the current one, so beats of successive requests run back to back.
   vpe_back u_back (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (!queue_empty),
      .item         (queue_item),
      .pop          (queue_pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_status   (rsp_status),
      .rsp_length   (rsp_length)
   );

endmodule

### hw/rtl/vpe_checker.sv
// Port-level checks of the encoder, bound to its top level.
module vpe_checker
   import vpe_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [2:0]  req_mode,
   input logic [63:0] req_value,
   input logic [3:0]  req_room,
   input logic        rsp_strobe,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_last,
   input logic [1:0]  rsp_status,
   input logic [3:0]  rsp_length
);

   // An error beat stands alone and carries neither a byte nor a length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != ST_OK)
      |-> rsp_last && (rsp_out_byte == 8'h00) && (rsp_length == 4'd0))
      else $error("error beat is not a lone empty beat");

   // The bytes of one encoding follow one another with no gap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("gap inside an encoding");

   // Length and status hold across the bytes of one encoding.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> $stable(rsp_length) && (rsp_status == ST_OK))
      else $error("length or status changed inside an encoding");

   // A good encoding is one, two, three, four or eight bytes long.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == ST_OK)
      |-> (rsp_length == 4'd1) || (rsp_length == 4'd2) || (rsp_length == 4'd3)
          || (rsp_length == 4'd4) || (rsp_length == 4'd8))
      else $error("unexpected encoding length");

   // Reset drops any beats in flight.
   assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("beat shown straight after reset");

endmodule

bind varint_prefix_encoder vpe_checker u_vpe_checker (.*);

### sim/tb_top.sv
// Self-checking testbench of the length-prefixed varint encoder.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import vpe_pkg::*;

   // Overview
   // --------
   // Requests go in on the command channel: start is raised and held until a
   // rising edge at which busy is low. A monitor notes each accepted request
   // in the scoreboard. The scoreboard works out the bytes that the request
   // must give and queues them. A second monitor takes every strobed response
   // beat and checks it against the oldest beat still awaited. The receiver
   // cannot hold beats off, so only the sender idles. It idles in random bursts,
   // and in the closing stretch of the run it does not idle at all.

   localparam int RANDOM_ITEMS   = 206;
   localparam int CALM_TAIL      = 40;   // last items sent without any idling
   localparam int END_SETTLE     = 24;   // quiet cycles after the last beat
   localparam int WATCHDOG_LIMIT = 400;  // cycles with no beat in either direction
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [7:0] octet;
      logic       last;
      logic [1:0] status;
      logic [3:0] length;
   } enc_beat_type;

   // The scoreboard holds its own prediction of the encoding and a queue of
   // the response beats still to come.
   class encode_scoreboard;
      enc_beat_type awaited_beats[$];
      int           failures;

      function new();
         failures = 0;
      endfunction

      function int outstanding();
         return awaited_beats.size();
      endfunction

      // An error is a single beat that carries a zero byte and a zero length.
      function void push_error(input logic [1:0] code);
         enc_beat_type b;
         b.octet  = 8'h00;
         b.last   = 1'b1;
         b.status = code;
         b.length = 4'd0;
         awaited_beats.push_back(b);
      endfunction

      // Works out the beats that one accepted request must give.
      function void note_request(input logic [2:0] mode, input logic [63:0] value,
                                 input logic [3:0] room);
         logic [63:0]  mask;
         logic [63:0]  raw;
         logic [63:0]  mag;
         logic [63:0]  bound[4];
         int           lens[4];
         logic [7:0]   sign_bit;
         logic [7:0]   first_tag;
         logic [7:0]   octet;
         logic         negative;
         int           width;
         int           ncls;
         int           chosen;
         int           nbytes;
         int           k;
         enc_beat_type b;

         case (mode) inside
            MODE_S16, MODE_U16: begin
               width = 16;
               ncls  = 2;
               if (mode == MODE_S16) begin
                  bound = '{64'h3F, 64'h3FFF, 64'h0, 64'h0};
               end else begin
                  bound = '{64'h7F, 64'h7FFF, 64'h0, 64'h0};
               end
               lens  = '{1, 2, 0, 0};
            end
            MODE_S32, MODE_U32: begin
               width = 32;
               ncls  = 4;
               if (mode == MODE_S32) begin
                  bound = '{64'h1F, 64'h1FFF, 64'h1F_FFFF, 64'h1FFF_FFFF};
               end else begin
                  bound = '{64'h3F, 64'h3FFF, 64'h3F_FFFF, 64'h3FFF_FFFF};
               end
               lens  = '{1, 2, 3, 4};
            end
            MODE_S64, MODE_U64: begin
               width = 64;
               ncls  = 4;
               if (mode == MODE_S64) begin
                  bound = '{64'h1F, 64'h1FFF, 64'h1FFF_FFFF, 64'h1FFF_FFFF_FFFF_FFFF};
               end else begin
                  bound = '{64'h3F, 64'h3FFF, 64'h3FFF_FFFF, 64'h3FFF_FFFF_FFFF_FFFF};
               end
               lens  = '{1, 2, 4, 8};
            end
            default: begin
               // The two unused mode codes are answered as out of range.
               push_error(ST_RANGE);
               return;
            end
         endcase

         sign_bit = (mode == MODE_S16) ? 8'h40 :
                    (mode == MODE_S32 || mode == MODE_S64) ? 8'h20 : 8'h00;
         mask     = (width == 64) ? '1 : ((64'h1 << width) - 64'h1);
         raw      = value & mask;
         negative = (sign_bit != 8'h00) && raw[width-1];
         mag      = negative ? ((~raw + 64'h1) & mask) : raw;

         chosen = -1;
         for (k = 0; k < ncls; k++) begin
            if (chosen < 0 && mag <= bound[k]) begin
               chosen = k;
            end
         end
         // The range test comes first; the most negative value fails it too.
         if (chosen < 0) begin
            push_error(ST_RANGE);
            return;
         end
         nbytes = lens[chosen];
         if (int'(room) < nbytes) begin
            push_error(ST_ROOM);
            return;
         end

         first_tag = (width == 16) ? ((chosen == 0) ? 8'h00 : 8'h80) : 8'(chosen << 6);
         for (k = 0; k < nbytes; k++) begin
            octet = 8'(mag >> (8 * (nbytes - 1 - k)));
            if (k == 0) begin
               octet = octet | first_tag | (negative ? sign_bit : 8'h00);
            end
            b.octet  = octet;
            b.last   = (k == nbytes - 1);
            b.status = ST_OK;
            b.length = 4'(nbytes);
            awaited_beats.push_back(b);
         end
      endfunction

      function void report(input string what, input enc_beat_type awaited,
                           input enc_beat_type got);
         failures++;
         if (failures <= REPORT_LIMIT) begin
            $display("%s: expected byte %h last %b status %0d length %0d,",
                     what, awaited.octet, awaited.last, awaited.status, awaited.length,
                     " got byte %h last %b status %0d length %0d",
                     got.octet, got.last, got.status, got.length);
         end
      endfunction

      function void check_beat(input enc_beat_type got);
         enc_beat_type awaited;
         if (awaited_beats.size() == 0) begin
            report("unexpected beat", '0, got);
            return;
         end
         awaited = awaited_beats.pop_front();
         if (got.octet !== awaited.octet || got.last !== awaited.last ||
             got.status !== awaited.status || got.length !== awaited.length) begin
            report("beat mismatch", awaited, got);
         end
      endfunction
   endclass

   // Clock, reset and block inputs. Every input starts at a known value.
   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   logic [2:0]  req_mode  = MODE_S16;
   logic [63:0] req_value = 64'h0;
   logic [3:0]  req_room  = 4'd0;
   logic        busy;
   logic        rsp_strobe;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_length;

   encode_scoreboard ledger;
   int               quiet_cycles = 0;

   always #4ns clock = ~clock;

   varint_prefix_encoder DUT (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_value    (req_value),
      .req_room     (req_room),
      .rsp_strobe   (rsp_strobe),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_status   (rsp_status),
      .rsp_length   (rsp_length)
   );

   // Both monitors sample at the rising edge, so they see the values that
   // stood during the cycle that the edge closes.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         ledger.note_request(req_mode, req_value, req_room);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         ledger.check_beat({rsp_out_byte, rsp_last, rsp_status, rsp_length});
      end
   end

   // The watchdog counts cycles in which no beat moves in either direction.
   // The longest quiet spell of a correct run is an idle burst plus the
   // pipeline latency, or the settling time at the end; the limit is well above.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Presents one request and holds it until the block takes it. It is
   // called at a rising edge and returns at the edge that accepted the beat.
   task automatic send_request(input logic [2:0] mode, input logic [63:0] value,
                               input logic [3:0] room);
      req_mode  <= mode;
      req_value <= value;
      req_room  <= room;
      start     <= 1'b1;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   task automatic idle_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Holds the sender off until every awaited beat has come back.
   task automatic wait_drained();
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (ledger.outstanding() != 0);
   endtask

   // The boundaries of every type, both signs, the most negative values,
   // the unused modes, and the room checks, including their order.
   task automatic run_directed();
      send_request(MODE_S16, 64'h0,                   4'd1);
      send_request(MODE_S16, 64'h3F,                  4'd1);
      send_request(MODE_S16, 64'hFFFF_FFFF_FFFF_0040, 4'd2);  // high junk is ignored
      send_request(MODE_S16, 64'hFFFF,                4'd8);  // minus one
      send_request(MODE_S16, 64'hC001,                4'd2);  // largest negative magnitude
      send_request(MODE_S16, 64'h8000,                4'd15); // most negative value
      send_request(MODE_S16, 64'h4000,                4'd8);
      send_request(MODE_U16, 64'h7F,                  4'd1);
      send_request(MODE_U16, 64'h7FFF,                4'd2);
      send_request(MODE_U16, 64'hFFFF,                4'd8);
      send_request(MODE_S32, 64'hE000_0001,           4'd4);
      send_request(MODE_S32, 64'h8000_0000,           4'd0);  // range wins over room
      send_request(MODE_S32, 64'h1F_FFFF,             4'd3);
      send_request(MODE_U32, 64'h3FFF_FFFF,           4'd3);  // one byte short
      send_request(MODE_U32, 64'h4000_0000,           4'd8);
      send_request(MODE_S64, 64'h1FFF_FFFF_FFFF_FFFF, 4'd8);
      send_request(MODE_S64, 64'hE000_0000_0000_0001, 4'd15);
      send_request(MODE_S64, 64'h8000_0000_0000_0000, 4'd8);
      send_request(MODE_S64, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0);  // no room at all
      send_request(MODE_U64, 64'h3FFF_FFFF_FFFF_FFFF, 4'd8);
      send_request(MODE_U64, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
      send_request(MODE_U64, 64'h3FFF_FFFF,           4'd4);
      send_request(3'd6,     64'h0,                   4'd8);  // unused mode codes
      send_request(3'd7,     64'h1,                   4'd15);
   endtask

   // Random requests. Most values are built from a magnitude of random bit
   // length so that every length class is reached; some are fully random.
   task automatic run_random();
      logic [2:0]  mode;
      logic [63:0] value;
      logic [3:0]  room;
      int          width;
      int          calm_left;
      int          i;

      calm_left = 0;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         mode  = ($urandom_range(0, 19) < 18) ? 3'($urandom_range(0, 5))
                                              : 3'($urandom_range(6, 7));
         width = (mode == MODE_S16 || mode == MODE_U16) ? 16 :
                 (mode == MODE_S32 || mode == MODE_U32) ? 32 : 64;
         case ($urandom_range(0, 4))
            0: value = {$urandom, $urandom};
            1: value = (64'h1 << $urandom_range(1, width)) - 64'h1;  // all-ones edges
            default: value = {$urandom, $urandom} >> $urandom_range(64 - width, 63);
         endcase
         if ((mode == MODE_S16 || mode == MODE_S32 || mode == MODE_S64) &&
             $urandom_range(0, 1) == 1) begin
            value = -value;
         end
         if (width < 64 && $urandom_range(0, 2) == 0) begin
            value = value | ({$urandom, $urandom} << width);
         end
         room = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 8))
                                            : 4'($urandom_range(0, 15));

         send_request(mode, value, room);

         // Idle bursts fall at random points of the encoder's work, with
         // calm stretches in between and none at all near the end.
         if (i >= RANDOM_ITEMS - CALM_TAIL) begin
            // closing stretch: back to back
         end else if (calm_left > 0) begin
            calm_left--;
         end else if ($urandom_range(0, 49) == 0) begin
            wait_drained();
         end else if ($urandom_range(0, 9) == 0) begin
            calm_left = $urandom_range(5, 20);
         end else if ($urandom_range(0, 2) == 0) begin
            idle_sender($urandom_range(1, 12));
         end
      end
   endtask

   initial begin
      ledger = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      // The sender waits here until the block has answered everything.
      wait_drained();
      run_random();
      wait_drained();
      repeat (END_SETTLE) @(posedge clock);

      if (ledger.failures == 0 && ledger.outstanding() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/vpe_pkg.sv
hw/rtl/vpe_front.sv
hw/rtl/vpe_queue.sv
hw/rtl/vpe_back.sv
hw/rtl/varint_prefix_encoder.sv
hw/rtl/vpe_checker.sv
sim/tb_top.sv
